>>> rtl/irtx_pkg.sv
// Shared types and constants for the infrared frame transmitter.
// No dependencies; every other file of the block but irtx_if imports this package.
package irtx_pkg;

  // Number of data bits in one frame and the width of the bit counter.
  localparam int FRAME_BITS = 32;
  localparam int IDX_W      = $clog2(FRAME_BITS);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // Input item opcodes.
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ADDR_FIRST   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDR_SECOND  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HDR_MARK     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HDR_SPACE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_MARK     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_SPACE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_SPACE   = 3'd6;

  // Register values after reset.
  localparam logic [7:0] RST_ADDR_FIRST  = 8'd255;
  localparam logic [7:0] RST_ADDR_SECOND = 8'd255;
  localparam logic [7:0] RST_HDR_MARK    = 8'd223;
  localparam logic [7:0] RST_HDR_SPACE   = 8'd117;
  localparam logic [7:0] RST_BIT_MARK    = 8'd10;
  localparam logic [7:0] RST_ONE_SPACE   = 8'd15;
  localparam logic [7:0] RST_ZERO_SPACE  = 8'd41;

  typedef struct packed {
    logic [7:0] address_first;
    logic [7:0] address_second;
    logic [7:0] header_mark_ticks;
    logic [7:0] header_space_ticks;
    logic [7:0] bit_mark_ticks;
    logic [7:0] one_space_ticks;
    logic [7:0] zero_space_ticks;
  } cfg_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic frame_done;
  } res_t;

endpackage

>>> rtl/irtx_if.sv
// Valid/ready channel interfaces for the infrared frame transmitter.
// Depends on nothing; the payload widths follow the block's item fields.
interface irtx_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] code_byte;

  modport source (output valid, output cmd, output code_byte, input ready);
  modport sink   (input valid, input cmd, input code_byte, output ready);
endinterface

interface irtx_out_if;
  logic valid;
  logic ready;
  logic line_level;
  logic busy_res;
  logic frame_done;

  modport source (output valid, output line_level, output busy_res, output frame_done,
                  input ready);
  modport sink   (input valid, input line_level, input busy_res, input frame_done,
                  output ready);
endinterface

>>> rtl/irtx_fsm.sv
// Frame sequencer: phase, bit counter, segment timer and line level.
// Depends on irtx_pkg for the configuration and result types.
module irtx_fsm (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  logic          cmd,
  input  logic [7:0]    code_byte,
  input  irtx_pkg::cfg_t cfg,
  output irtx_pkg::res_t res
);
  import irtx_pkg::*;

  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_HDR_MARK  = 3'd1;
  localparam logic [2:0] PH_HDR_SPACE = 3'd2;
  localparam logic [2:0] PH_BIT_MARK  = 3'd3;
  localparam logic [2:0] PH_BIT_SPACE = 3'd4;
  localparam logic [2:0] PH_END_MARK  = 3'd5;

  localparam logic [IDX_W-1:0] LAST_BIT = IDX_W'(FRAME_BITS - 1);

  logic [2:0]            phase, phase_next;
  logic [IDX_W-1:0]      bit_index, bit_index_next;
  logic [FRAME_BITS-1:0] frame_bits, frame_bits_next;
  logic [7:0]            seg_left, seg_left_next;
  logic                  level, level_next;
  logic                  done;
  logic [31:0]           word;

  // Address bytes first, then the command and its complement.
  assign word = {~code_byte, code_byte, cfg.address_second, cfg.address_first};

  always_comb begin
    phase_next      = phase;
    bit_index_next  = bit_index;
    frame_bits_next = frame_bits;
    seg_left_next   = seg_left;
    level_next      = level;
    done            = 1'b0;
    if (take) begin
      if (cmd == CMD_START) begin
        // A start during a frame is dropped.
        if (phase == PH_IDLE) begin
          frame_bits_next = word[FRAME_BITS-1:0];
          bit_index_next  = '0;
          phase_next      = PH_HDR_MARK;
          seg_left_next   = cfg.header_mark_ticks;
          level_next      = 1'b0;
        end
      end else if (phase != PH_IDLE) begin
        // A length of zero runs out on the first tick, the same as one.
        if (seg_left > 8'd1) begin
          seg_left_next = seg_left - 8'd1;
        end else begin
          case (phase)
            PH_HDR_MARK: begin
              phase_next    = PH_HDR_SPACE;
              seg_left_next = cfg.header_space_ticks;
              level_next    = 1'b1;
            end
            PH_HDR_SPACE: begin
              phase_next    = PH_BIT_MARK;
              seg_left_next = cfg.bit_mark_ticks;
              level_next    = 1'b0;
            end
            PH_BIT_MARK: begin
              phase_next    = PH_BIT_SPACE;
              seg_left_next = frame_bits[bit_index] ? cfg.one_space_ticks
                                                    : cfg.zero_space_ticks;
              level_next    = 1'b1;
            end
            PH_BIT_SPACE: begin
              if (bit_index >= LAST_BIT) begin
                phase_next = PH_END_MARK;
              end else begin
                bit_index_next = bit_index + 1'b1;
                phase_next     = PH_BIT_MARK;
              end
              seg_left_next = cfg.bit_mark_ticks;
              level_next    = 1'b0;
            end
            default: begin
              phase_next     = PH_IDLE;
              seg_left_next  = 8'd0;
              level_next     = 1'b1;
              bit_index_next = '0;
              done           = 1'b1;
            end
          endcase
        end
      end
    end
  end

  assign res = '{line_level: level_next,
                 busy_res:   (phase_next != PH_IDLE),
                 frame_done: done};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      bit_index <= '0;
      seg_left  <= 8'd0;
      level     <= 1'b1;
    end else begin
      phase     <= phase_next;
      bit_index <= bit_index_next;
      seg_left  <= seg_left_next;
      level     <= level_next;
    end
  end

  always_ff @(posedge clk) begin
    frame_bits <= frame_bits_next;
  end

endmodule

>>> rtl/irtx_res_buf.sv
// Two-entry result buffer that decouples the result channel from the input side.
// Depends on irtx_pkg for the result type.
module irtx_res_buf (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  irtx_pkg::res_t push_data,
  output logic           has_room,
  output logic           head_valid,
  input  logic           pop,
  output irtx_pkg::res_t head
);
  import irtx_pkg::*;

  logic [1:0] count, count_next;
  res_t       second;

  assign has_room   = (count != 2'd2);
  assign head_valid = (count != 2'd0);

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push && (count == 2'd0 || (count == 2'd1 && pop))) begin
      head <= push_data;
    end else if (pop && count == 2'd2) begin
      head <= second;
    end
    if (push && count == 2'd1 && !pop) begin
      second <= push_data;
    end
  end

endmodule

>>> rtl/ir_remote_frame_transmitter_core.sv
// Top level of the pulse-distance infrared frame transmitter.
// Depends on irtx_pkg, irtx_if, irtx_fsm and irtx_res_buf.
//
//   channel   direction  handshake     payload
//   items     in         valid/ready   cmd, code_byte
//   results   out        valid/ready   line_level, busy_res, frame_done
//   wr_*      in         wr_en only    wr_index, wr_data
//
// Every input transfer yields exactly one result transfer. A start item
// loads the frame word (both address bytes, the command byte and its
// complement) when the transmitter is idle and is dropped otherwise. Tick
// items count down the current segment: header mark, header space, one mark
// and one space per data bit sent LSB first, and a closing mark whose last
// tick raises frame_done.
//
// Timing: one item per cycle while the buffer has room. The sequencer state
// updates at the transfer edge, and the result is registered in a two-entry
// buffer and offered on the results channel once earlier results are taken.
// Reset (rst, synchronous, active high) returns the configuration registers
// to their defaults, idles the sequencer with the line high and empties the
// buffer. items.ready drops only when both buffer entries hold results that
// have not been taken; it rises again in the cycle after a result transfer.
// Configuration writes take effect at the next edge. A length written during
// a frame applies from the next segment that starts, and new address bytes
// apply from the next start.
module ir_remote_frame_transmitter_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [irtx_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [irtx_pkg::CFG_DATA_W-1:0] wr_data,
  irtx_in_if.sink                       items,
  irtx_out_if.source                    results
);
  import irtx_pkg::*;

  cfg_t cfg;
  res_t fsm_res;
  res_t head;
  logic take;
  logic has_room;
  logic head_valid;

  // Register file. Writes to the index beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{address_first:      RST_ADDR_FIRST,
               address_second:     RST_ADDR_SECOND,
               header_mark_ticks:  RST_HDR_MARK,
               header_space_ticks: RST_HDR_SPACE,
               bit_mark_ticks:     RST_BIT_MARK,
               one_space_ticks:    RST_ONE_SPACE,
               zero_space_ticks:   RST_ZERO_SPACE};
    end else if (wr_en) begin
      case (wr_index)
        CFG_ADDR_FIRST:  cfg.address_first      <= wr_data;
        CFG_ADDR_SECOND: cfg.address_second     <= wr_data;
        CFG_HDR_MARK:    cfg.header_mark_ticks  <= wr_data;
        CFG_HDR_SPACE:   cfg.header_space_ticks <= wr_data;
        CFG_BIT_MARK:    cfg.bit_mark_ticks     <= wr_data;
        CFG_ONE_SPACE:   cfg.one_space_ticks    <= wr_data;
        CFG_ZERO_SPACE:  cfg.zero_space_ticks   <= wr_data;
        default: begin
        end
      endcase
    end
  end

  // An input transfer happens whenever an item is valid and the buffer has a free entry.
  assign items.ready = has_room;
  assign take        = items.valid && has_room;

  irtx_fsm u_fsm (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .cmd       (items.cmd),
    .code_byte (items.code_byte),
    .cfg       (cfg),
    .res       (fsm_res)
  );

  irtx_res_buf u_res_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (take),
    .push_data  (fsm_res),
    .has_room   (has_room),
    .head_valid (head_valid),
    .pop        (head_valid && results.ready),
    .head       (head)
  );

  assign results.valid      = head_valid;
  assign results.line_level = head.line_level;
  assign results.busy_res   = head.busy_res;
  assign results.frame_done = head.frame_done;

endmodule

>>> tb/sv/ir_remote_frame_transmitter_core_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for ir_remote_frame_transmitter_core.
// Depends on irtx_pkg, the irtx_in_if/irtx_out_if interfaces and the core RTL.
module ir_remote_frame_transmitter_core_test;
  import irtx_pkg::*;

  // Cycles with no transfer on either channel before the run is declared hung.
  // The slowest legal gap is a register programming burst or a receiver stall.
  localparam int STALL_LIMIT = 4000;
  // Cycles to keep watching after the last expected result, so that a stray
  // extra result from the two-entry buffer would still be seen.
  localparam int TAIL_CYCLES = 8;
  // Target number of frame-advancing transfers in the random section.
  localparam int RANDOM_WORK = 400;

  // Index 7 is not a register; a write to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  localparam cfg_t RESET_CFG = '{RST_ADDR_FIRST, RST_ADDR_SECOND, RST_HDR_MARK,
                                 RST_HDR_SPACE, RST_BIT_MARK, RST_ONE_SPACE,
                                 RST_ZERO_SPACE};

  // Segments of a frame as the sequencer walks through them.
  typedef enum logic [2:0] {
    SEG_IDLE, SEG_HDR_MARK, SEG_HDR_SPACE, SEG_BIT_MARK, SEG_BIT_SPACE, SEG_END_MARK
  } seg_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] code;
  } tx_item_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  wr_en;
  logic [CFG_IDX_W-1:0]  wr_index;
  logic [CFG_DATA_W-1:0] wr_data;

  irtx_in_if  items_ch();
  irtx_out_if results_ch();

  ir_remote_frame_transmitter_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .items    (items_ch),
    .results  (results_ch)
  );

  always #6 clk = ~clk;

  // Items waiting to be offered, and the line status predicted for every
  // item the block has taken but whose result has not come back yet.
  tx_item_t tx_queue[$];
  res_t     expected_status[$];

  int  items_queued  = 0;
  int  items_taken   = 0;
  int  results_seen  = 0;
  int  mismatches    = 0;
  int  frames_sent   = 0;
  int  settings_used = 0;
  int  quiet_cycles  = 0;
  // While set, neither side inserts idle cycles.
  bit  steady = 1'b0;

  // Register values as the stimulus side last programmed them; used only to
  // work out how many ticks a frame needs.
  cfg_t plan_cfg = RESET_CFG;

  // Predictor state: its own copy of the registers and of the sequencer.
  cfg_t                live_cfg;
  seg_t                seg;
  logic [IDX_W-1:0]    bit_pos;
  logic [FRAME_BITS-1:0] word;
  logic [7:0]          ticks_left;
  logic                level;

  tx_item_t pick;
  res_t     want;

  // Returns the register set with one write applied. Unknown indexes are
  // dropped, as the block does.
  function automatic cfg_t with_setting(cfg_t c, logic [CFG_IDX_W-1:0] idx,
                                        logic [7:0] val);
    cfg_t n;
    n = c;
    case (idx)
      CFG_ADDR_FIRST:  n.address_first      = val;
      CFG_ADDR_SECOND: n.address_second     = val;
      CFG_HDR_MARK:    n.header_mark_ticks  = val;
      CFG_HDR_SPACE:   n.header_space_ticks = val;
      CFG_BIT_MARK:    n.bit_mark_ticks     = val;
      CFG_ONE_SPACE:   n.one_space_ticks    = val;
      CFG_ZERO_SPACE:  n.zero_space_ticks   = val;
      default: ;
    endcase
    return n;
  endfunction

  function automatic void enter_segment(seg_t s, logic [7:0] len, logic lvl);
    seg        = s;
    ticks_left = len;
    level      = lvl;
  endfunction

  // Applies one item to the predicted sequencer and returns the status the
  // block must report for it. A segment of length N ends on its Nth tick,
  // and that tick already shows the level of the following segment. A length
  // of zero behaves like one, since the countdown only decrements above one.
  function automatic res_t advance_transmitter(logic c, logic [7:0] code);
    res_t r;
    logic done;
    done = 1'b0;
    if (c == CMD_START) begin
      // A start is only taken while idle; otherwise the status is just echoed.
      if (seg == SEG_IDLE) begin
        word    = {~code, code, live_cfg.address_second, live_cfg.address_first};
        bit_pos = '0;
        enter_segment(SEG_HDR_MARK, live_cfg.header_mark_ticks, 1'b0);
      end
    end else if (seg != SEG_IDLE) begin
      if (ticks_left > 8'd1) begin
        ticks_left = ticks_left - 8'd1;
      end else begin
        case (seg)
          SEG_HDR_MARK:  enter_segment(SEG_HDR_SPACE, live_cfg.header_space_ticks, 1'b1);
          SEG_HDR_SPACE: enter_segment(SEG_BIT_MARK, live_cfg.bit_mark_ticks, 1'b0);
          SEG_BIT_MARK: begin
            if (word[bit_pos]) enter_segment(SEG_BIT_SPACE, live_cfg.one_space_ticks, 1'b1);
            else enter_segment(SEG_BIT_SPACE, live_cfg.zero_space_ticks, 1'b1);
          end
          SEG_BIT_SPACE: begin
            if (int'(bit_pos) >= FRAME_BITS - 1) begin
              enter_segment(SEG_END_MARK, live_cfg.bit_mark_ticks, 1'b0);
            end else begin
              bit_pos = bit_pos + 1'b1;
              enter_segment(SEG_BIT_MARK, live_cfg.bit_mark_ticks, 1'b0);
            end
          end
          default: begin
            // The closing mark has run out: the frame is over.
            enter_segment(SEG_IDLE, 8'd0, 1'b1);
            bit_pos = '0;
            done    = 1'b1;
          end
        endcase
      end
    end
    r.line_level = level;
    r.busy_res   = (seg != SEG_IDLE);
    r.frame_done = done;
    return r;
  endfunction

  function automatic int seg_len(logic [7:0] len);
    return (len == 8'd0) ? 1 : int'(len);
  endfunction

  // Number of ticks from the start of the mark of data bit first_bit up to and
  // including the tick that raises frame_done, under the programmed lengths.
  function automatic int frame_rest(logic [7:0] code, int first_bit);
    logic [FRAME_BITS-1:0] w;
    int n;
    w = {~code, code, plan_cfg.address_second, plan_cfg.address_first};
    n = seg_len(plan_cfg.bit_mark_ticks);
    for (int b = first_bit; b < FRAME_BITS; b++) begin
      n += seg_len(plan_cfg.bit_mark_ticks)
           + (w[b] ? seg_len(plan_cfg.one_space_ticks) : seg_len(plan_cfg.zero_space_ticks));
    end
    return n;
  endfunction

  // Number of ticks from a start on `code` up to and including the tick that
  // raises frame_done, under the currently programmed lengths.
  function automatic int frame_len(logic [7:0] code);
    return seg_len(plan_cfg.header_mark_ticks) + seg_len(plan_cfg.header_space_ticks)
           + frame_rest(code, 0);
  endfunction

  // Driver and input-side predictor. A new item is offered only once the
  // previous one has been transferred; each transfer is run through the
  // predictor at the same edge at which the block takes it, with the
  // registers as they stood before any write landing at that edge.
  always @(posedge clk) begin
    if (rst) begin
      items_ch.valid <= 1'b0;
      live_cfg   = RESET_CFG;
      seg        = SEG_IDLE;
      bit_pos    = '0;
      word       = '0;
      ticks_left = 8'd0;
      level      = 1'b1;
    end else begin
      if (items_ch.valid && items_ch.ready) begin
        expected_status.push_back(advance_transmitter(items_ch.cmd, items_ch.code_byte));
        items_taken++;
      end
      if (wr_en) live_cfg = with_setting(live_cfg, wr_index, wr_data);
      if (!items_ch.valid || items_ch.ready) begin
        if (tx_queue.size() != 0 && (steady || $urandom_range(99) >= 28)) begin
          pick = tx_queue.pop_front();
          items_ch.valid     <= 1'b1;
          items_ch.cmd       <= pick.cmd;
          items_ch.code_byte <= pick.code;
        end else begin
          items_ch.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string field, logic exp_bit, logic got_bit);
    if (got_bit !== exp_bit) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0b, got %0b", $time, field, exp_bit, got_bit);
    end
  endtask

  // Result monitor: applies random back-pressure and compares every result
  // transfer with the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      results_ch.ready <= 1'b0;
    end else begin
      results_ch.ready <= steady || ($urandom_range(99) >= 28);
      if (results_ch.valid && results_ch.ready) begin
        results_seen++;
        if (expected_status.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, got line %0b busy %0b done %0b",
                   $time, results_ch.line_level, results_ch.busy_res, results_ch.frame_done);
        end else begin
          want = expected_status.pop_front();
          check_field("line_level", want.line_level, results_ch.line_level);
          check_field("busy_res", want.busy_res, results_ch.busy_res);
          check_field("frame_done", want.frame_done, results_ch.frame_done);
        end
      end
    end
  end

  // Watchdog: a long run of cycles with no transfer at all means the block
  // has hung, so the run is ended there.
  always @(posedge clk) begin
    if (rst || (items_ch.valid && items_ch.ready) || (results_ch.valid && results_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("ir_remote_frame_transmitter_core test failed");
        $finish;
      end
    end
  end

  task automatic push_item(logic c, logic [7:0] code);
    tx_item_t it;
    it.cmd  = c;
    it.code = code;
    tx_queue.push_back(it);
    items_queued++;
  endtask

  // Queues n ticks for a frame in progress. Before each tick a start with a
  // random byte may slip in; the block is busy at every such point, so it
  // must drop those starts.
  task automatic queue_ticks(int n, int noise_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < noise_pct) push_item(CMD_START, 8'($urandom_range(255)));
      push_item(CMD_TICK, 8'($urandom_range(255)));
    end
  endtask

  // Queues a start and every tick its frame needs. Returns the number of
  // transfers that move the frame along.
  task automatic queue_frame(logic [7:0] code, int noise_pct, output int work);
    int n;
    n = frame_len(code);
    push_item(CMD_START, code);
    queue_ticks(n, noise_pct);
    frames_sent++;
    work = n + 1;
  endtask

  // Holds the sender until every queued item is taken and every predicted
  // result has come back.
  task automatic wait_for_results();
    while (items_taken != items_queued || expected_status.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    plan_cfg = with_setting(plan_cfg, idx, val);
  endtask

  task automatic end_writes();
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic program_all(logic [7:0] a1, logic [7:0] a2, logic [7:0] hm,
                             logic [7:0] hs, logic [7:0] bm, logic [7:0] one_len,
                             logic [7:0] zero_len);
    write_reg(CFG_ADDR_FIRST, a1);
    write_reg(CFG_ADDR_SECOND, a2);
    write_reg(CFG_HDR_MARK, hm);
    write_reg(CFG_HDR_SPACE, hs);
    write_reg(CFG_BIT_MARK, bm);
    write_reg(CFG_ONE_SPACE, one_len);
    write_reg(CFG_ZERO_SPACE, zero_len);
    end_writes();
    settings_used++;
  endtask

  // Mostly very short segments so that several frames fit in the run; now
  // and then a longer one, and now and then a zero.
  function automatic logic [7:0] random_len();
    int r;
    r = $urandom_range(19);
    if (r == 0) return 8'd0;
    if (r < 3) return 8'($urandom_range(4, 12));
    return 8'($urandom_range(1, 2));
  endfunction

  initial begin
    int work;
    int random_work;
    int frames_in_setting;
    int n;
    logic [7:0] code;

    rst                 = 1'b1;
    wr_en               = 1'b0;
    wr_index            = '0;
    wr_data             = '0;
    items_ch.valid      = 1'b0;
    items_ch.cmd        = CMD_TICK;
    items_ch.code_byte  = 8'h00;
    results_ch.ready    = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part. The lowest address bit is cleared so that the first data
    // bit uses the zero space; every length keeps its reset value.
    write_reg(CFG_ADDR_FIRST, 8'hFE);
    end_writes();
    // Ticks while idle must leave the line high and not busy.
    push_item(CMD_TICK, 8'h00);
    push_item(CMD_TICK, 8'hFF);
    // One frame with the reset timing through the first two data bits; a
    // second start right behind the first lands while busy and must be
    // dropped. The sender stops with one tick of the second space left.
    code = 8'h00;
    n = seg_len(plan_cfg.header_mark_ticks) + seg_len(plan_cfg.header_space_ticks)
        + 2 * seg_len(plan_cfg.bit_mark_ticks) + seg_len(plan_cfg.zero_space_ticks)
        + seg_len(plan_cfg.one_space_ticks) - 1;
    push_item(CMD_START, code);
    push_item(CMD_START, 8'hFF);
    queue_ticks(n, 1);
    frames_sent++;
    wait_for_results();
    // Shorter bit timing written during the frame applies from the mark of
    // the third data bit on.
    write_reg(CFG_BIT_MARK, 8'd1);
    write_reg(CFG_ONE_SPACE, 8'd1);
    write_reg(CFG_ZERO_SPACE, 8'd1);
    end_writes();
    queue_ticks(1 + frame_rest(code, 2), 1);
    wait_for_results();

    // Shortest legal segments; two frames back to back, the second start
    // arriving right after the tick that ends the first frame.
    program_all(8'h00, 8'hFF, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1);
    queue_frame(8'hFF, 0, work);
    queue_frame(8'hA5, 5, work);
    push_item(CMD_TICK, 8'h3C);
    wait_for_results();

    // Zero lengths behave as one tick. The write to the spare index must be
    // ignored by the block.
    program_all(8'h80, 8'h01, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    write_reg(CFG_SPARE, 8'h01);
    end_writes();
    queue_frame(8'h5A, 3, work);
    wait_for_results();

    // Longest header mark, run without any idle cycles on either side.
    program_all(8'hFF, 8'h00, 8'd255, 8'd1, 8'd1, 8'd1, 8'd1);
    steady = 1'b1;
    queue_frame(8'($urandom_range(255)), 0, work);
    wait_for_results();
    steady = 1'b0;

    // Address change halfway through a frame: the frame on the line keeps its
    // word, the new addresses show up in the next one.
    program_all(8'h12, 8'h34, 8'd3, 8'd2, 8'd1, 8'd2, 8'd3);
    code = 8'($urandom_range(255));
    n = frame_len(code);
    push_item(CMD_START, code);
    queue_ticks(n / 2, 0);
    frames_sent++;
    wait_for_results();
    write_reg(CFG_ADDR_FIRST, 8'($urandom_range(255)));
    write_reg(CFG_ADDR_SECOND, 8'($urandom_range(255)));
    end_writes();
    queue_ticks(n - n / 2, 0);
    queue_frame(8'($urandom_range(255)), 0, work);

    // Random part: whole frames with random bytes under random timing, with
    // stray starts and idle ticks mixed in. Every couple of frames the sender
    // drains and the registers get a fresh setting.
    random_work       = 0;
    frames_in_setting = 0;
    while (random_work < RANDOM_WORK) begin
      if (frames_in_setting >= 2) begin
        wait_for_results();
        program_all(8'($urandom_range(255)), 8'($urandom_range(255)), random_len(),
                    random_len(), random_len(), random_len(), random_len());
        if ($urandom_range(3) == 0) begin
          write_reg(CFG_SPARE, 8'($urandom_range(255)));
          end_writes();
        end
        frames_in_setting = 0;
      end
      queue_frame(8'($urandom_range(255)), ($urandom_range(3) == 0) ? 15 : 1, work);
      random_work += work;
      frames_in_setting++;
      if ($urandom_range(2) == 0) begin
        repeat ($urandom_range(1, 4)) push_item(CMD_TICK, 8'($urandom_range(255)));
      end
      while (tx_queue.size() > 32) @(posedge clk);
    end

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d frames under %0d register settings: %0d item transfers, %0d results.",
             frames_sent, settings_used, items_taken, results_seen);
    if (mismatches == 0 && expected_status.size() == 0) begin
      $display("ir_remote_frame_transmitter_core test passed");
    end else begin
      $display("ir_remote_frame_transmitter_core test failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/irtx_pkg.sv
rtl/irtx_if.sv
rtl/irtx_fsm.sv
rtl/irtx_res_buf.sv
rtl/ir_remote_frame_transmitter_core.sv
tb/sv/ir_remote_frame_transmitter_core_test.sv
